// ===== rtl/core/ccgf_pkg.sv =====
`timescale 1ns / 1ps

package ccgf_pkg;

  localparam int unsigned PixW          = 8;
  localparam int unsigned KernelTaps    = 9;
  localparam int unsigned CfgDataW      = 64;
  localparam int unsigned CfgIndexW     = 2;
  localparam int unsigned LineWidthW    = 11;
  localparam int unsigned FrameHeightW  = 16;
  localparam int unsigned DefMaxWidth   = 1024;

  localparam logic [LineWidthW-1:0]   LineWidthRst   = 11'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightRst = 16'd480;

  typedef logic [PixW-1:0] pix_t;

  // Nine bytes, element j in bits 8j+7..8j.
  typedef logic [KernelTaps-1:0][PixW-1:0] win_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_TAPS_LOW     = 2'd0,
    CFG_TAP_LAST     = 2'd1,
    CFG_LINE_WIDTH   = 2'd2,
    CFG_FRAME_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic interior;
    logic frame_end;
  } pos_flags_t;

endpackage

// ===== rtl/core/ccgf_pos_ctr.sv =====
`timescale 1ns / 1ps

module ccgf_pos_ctr
  import ccgf_pkg::*;
#(
  parameter int unsigned MaxWidth = DefMaxWidth,
  localparam int unsigned ColW = $clog2(MaxWidth)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  logic                    frame_start_i,
  input  logic [LineWidthW-1:0]   line_width_i,
  input  logic [FrameHeightW-1:0] frame_height_i,
  output logic [ColW-1:0]         col_o,
  output pos_flags_t              flags_o
);

  localparam int unsigned WW   = $clog2(MaxWidth + 1);
  localparam int unsigned CmpW = (WW > LineWidthW) ? WW : LineWidthW;

  logic [ColW-1:0]         col_q, col_d;
  logic [FrameHeightW-1:0] row_q, row_d;

  logic [CmpW-1:0]         lw_ext, eff_w, c_inc;
  logic [FrameHeightW-1:0] eff_h;
  logic [ColW-1:0]         col0, c;
  logic [FrameHeightW-1:0] row0, row1, r;
  logic [FrameHeightW:0]   r_inc;

  always_comb begin
    lw_ext = CmpW'(line_width_i);
    if (lw_ext < CmpW'(3)) begin
      eff_w = CmpW'(3);
    end else if (lw_ext > CmpW'(MaxWidth)) begin
      eff_w = CmpW'(MaxWidth);
    end else begin
      eff_w = lw_ext;
    end
    eff_h = (frame_height_i < FrameHeightW'(3)) ? FrameHeightW'(3) : frame_height_i;

    col0 = frame_start_i ? '0 : col_q;
    row0 = frame_start_i ? '0 : row_q;
    if (CmpW'(col0) >= eff_w) begin
      c    = '0;
      row1 = row0 + FrameHeightW'(1);
    end else begin
      c    = col0;
      row1 = row0;
    end
    r = (row1 >= eff_h) ? '0 : row1;

    c_inc = CmpW'(c) + CmpW'(1);
    r_inc = {1'b0, r} + (FrameHeightW+1)'(1);
    if (c_inc >= eff_w) begin
      col_d = '0;
      row_d = (r_inc >= {1'b0, eff_h}) ? '0 : r_inc[FrameHeightW-1:0];
    end else begin
      col_d = c_inc[ColW-1:0];
      row_d = r;
    end

    flags_o.interior  = (r >= FrameHeightW'(2)) && (CmpW'(c) >= CmpW'(2));
    flags_o.frame_end = (r == eff_h - FrameHeightW'(1)) && (CmpW'(c) == eff_w - CmpW'(1));
  end

  assign col_o = c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== rtl/core/ccgf_line_store.sv =====
`timescale 1ns / 1ps

module ccgf_line_store
  import ccgf_pkg::*;
#(
  parameter int unsigned MaxWidth = DefMaxWidth,
  localparam int unsigned ColW = $clog2(MaxWidth)
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [ColW-1:0] rd_addr_i,
  input  logic            wr_en_i,
  input  logic [ColW-1:0] wr_addr_i,
  input  pix_t            wr_a_i,
  input  pix_t            wr_b_i,
  output pix_t            rd_a_o,
  output pix_t            rd_b_o
);

  pix_t mem_a [MaxWidth];
  pix_t mem_b [MaxWidth];
  pix_t rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[wr_addr_i] <= wr_a_i;
      mem_b[wr_addr_i] <= wr_b_i;
    end
  end

  // A read of the column being written in the same cycle takes the new data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_a_q <= wr_a_i;
        rd_b_q <= wr_b_i;
      end else begin
        rd_a_q <= mem_a[rd_addr_i];
        rd_b_q <= mem_b[rd_addr_i];
      end
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ===== rtl/core/ccgf_mac_array.sv =====
`timescale 1ns / 1ps

module ccgf_mac_array
  import ccgf_pkg::*;
(
  input  win_t taps_i,
  input  win_t window_i,
  output pix_t sum_o
);

  // Tap i meets window element 8-i, which applies the kernel flipped.
  pix_t prod [KernelTaps];
  pix_t acc;

  always_comb begin
    for (int i = 0; i < KernelTaps; i++) begin
      prod[i] = PixW'(taps_i[i] * window_i[KernelTaps-1-i]);
    end
    acc = '0;
    for (int i = 0; i < KernelTaps; i++) begin
      acc = acc + prod[i];
    end
  end

  assign sum_o = acc;

endmodule

// ===== rtl/core/conv3x3_gray_filter_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  tdata              tuser
// s_axis    in         pixel_in [7:0]     frame_start
// m_axis    out        pixel_out [7:0]    frame_end
// cfg       in         cfg_data_i, cfg_index_i selects the register
//
// One pixel is accepted per clock while m_axis is not stalled; an interior pixel's result passes
// through the p1 stage and the output register. The rate is set by the two-port line stores,
// read on accept and written back from the p1 stage, with a same-column write forwarded to the
// read. Reset clears the position counters and the window and restores the configuration;
// line store contents stay undefined. A stall on m_axis holds the whole pipeline, and
// s_axis_tready drops only while a result waits.

module conv3x3_gray_filter_core
  import ccgf_pkg::*;
#(
  parameter int unsigned MaxWidth = DefMaxWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] pixel_in
  input  logic                 s_axis_tuser,   // [0] frame_start
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] pixel_out
  output logic                 m_axis_tuser    // [0] frame_end
);

  localparam int unsigned ColW = $clog2(MaxWidth);

  logic [CfgDataW-1:0]     taps_low_q;
  logic signed [PixW-1:0]  tap_last_q;
  logic [LineWidthW-1:0]   line_width_q;
  logic [FrameHeightW-1:0] frame_height_q;

  logic advance, accept, stage_go;

  logic [ColW-1:0] col;
  pos_flags_t      flags;

  logic            p1_valid_q;
  pix_t            p1_pix_q;
  logic [ColW-1:0] p1_col_q;
  pos_flags_t      p1_flags_q;

  pix_t up1, up2, sum;
  win_t window_q, window_d, taps;

  logic out_valid_q, out_end_q;
  pix_t out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_low_q     <= '0;
      tap_last_q     <= '0;
      line_width_q   <= LineWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TAPS_LOW:     taps_low_q     <= cfg_data_i;
        CFG_TAP_LAST:     tap_last_q     <= $signed(cfg_data_i[PixW-1:0]);
        CFG_LINE_WIDTH:   line_width_q   <= cfg_data_i[LineWidthW-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FrameHeightW-1:0];
      endcase
    end
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && advance;
  assign stage_go      = advance && p1_valid_q;
  assign s_axis_tready = advance;

  ccgf_pos_ctr #(
    .MaxWidth(MaxWidth)
  ) u_pos_ctr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (accept),
    .frame_start_i (s_axis_tuser),
    .line_width_i  (line_width_q),
    .frame_height_i(frame_height_q),
    .col_o         (col),
    .flags_o       (flags)
  );

  ccgf_line_store #(
    .MaxWidth(MaxWidth)
  ) u_line_store (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_addr_i(col),
    .wr_en_i  (stage_go),
    .wr_addr_i(p1_col_q),
    .wr_a_i   (p1_pix_q),
    .wr_b_i   (up1),
    .rd_a_o   (up1),
    .rd_b_o   (up2)
  );

  always_comb begin
    for (int rr = 0; rr < 3; rr++) begin
      window_d[rr*3]   = window_q[rr*3+1];
      window_d[rr*3+1] = window_q[rr*3+2];
    end
    window_d[2] = up2;
    window_d[5] = up1;
    window_d[8] = p1_pix_q;
  end

  assign taps = {$unsigned(tap_last_q), taps_low_q};

  ccgf_mac_array u_mac_array (
    .taps_i  (taps),
    .window_i(window_d),
    .sum_o   (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= '0;
    end else if (advance) begin
      p1_valid_q  <= accept;
      out_valid_q <= p1_valid_q && p1_flags_q.interior;
      if (p1_valid_q) begin
        window_q <= window_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_pix_q   <= s_axis_tdata;
      p1_col_q   <= col;
      p1_flags_q <= flags;
    end
    if (stage_go) begin
      out_pix_q <= sum;
      out_end_q <= p1_flags_q.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tuser  = out_end_q;

endmodule

// ===== bench/conv3x3_gray_filter_core_tb.sv =====
`timescale 1ns / 1ps

module conv3x3_gray_filter_core_tb;
  import ccgf_pkg::*;

  typedef struct packed {
    pix_t pixel;
    logic frame_start;
  } pix_beat_t;

  typedef struct packed {
    pix_t pixel;
    logic frame_end;
  } filt_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;   // [7:0] pixel_in
  logic                 s_axis_tuser = 1'b0; // [0] frame_start
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;        // [7:0] pixel_out
  logic                 m_axis_tuser;        // [0] frame_end

  pix_beat_t   pixel_q[$];
  filt_beat_t  filtered_q[$];
  int unsigned err_cnt = 0;
  int unsigned src_wait = 0;
  int unsigned snk_wait = 0;
  bit          src_idle_en = 1'b0;
  bit          snk_idle_en = 1'b0;
  logic        hold_sink = 1'b0;
  bit          stall_arm = 1'b0;

  // Shadow of the filter: configuration, line stores, window and position.
  logic [63:0]             kern_lo = '0;
  pix_t                    kern_last = '0;
  logic [LineWidthW-1:0]   cfg_width = LineWidthRst;
  logic [FrameHeightW-1:0] cfg_height = FrameHeightRst;
  pix_t                    line_a [DefMaxWidth] = '{default: 8'h00};
  pix_t                    line_b [DefMaxWidth] = '{default: 8'h00};
  pix_t                    win [9] = '{default: 8'h00};
  int unsigned             col_cnt = 0;
  int unsigned             row_cnt = 0;

  conv3x3_gray_filter_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (err_cnt < 40) begin
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
    err_cnt++;
  endtask

  task automatic filter_pixel(input pix_t px, input logic fs);
    int unsigned w, h, c, r;
    pix_t        up2, up1, coef;
    logic [7:0]  acc;
    filt_beat_t  res;
    w = (cfg_width < 3) ? 3 : ((cfg_width > DefMaxWidth) ? DefMaxWidth : cfg_width);
    h = (cfg_height < 3) ? 3 : cfg_height;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = row_cnt + 1;
    end
    if (row_cnt >= h) begin
      row_cnt = 0;
    end
    c = col_cnt;
    r = row_cnt;
    up2 = line_b[c];
    up1 = line_a[c];
    line_b[c] = up1;
    line_a[c] = px;
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = px;
    if (r >= 2 && c >= 2) begin
      // The kernel is applied flipped: tap (k, l) meets the pixel at offset (1-k, 1-l).
      acc = '0;
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          coef = (k*3 + l < 8) ? kern_lo[8*(k*3+l) +: 8] : kern_last;
          acc = acc + coef * win[(2-k)*3 + (2-l)];
        end
      end
      res.pixel = acc;
      res.frame_end = (r == h - 1) && (c == w - 1);
      filtered_q.push_back(res);
    end
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_TAPS_LOW:     kern_lo = val;
      CFG_TAP_LAST:     kern_last = val[7:0];
      CFG_LINE_WIDTH:   cfg_width = val[LineWidthW-1:0];
      CFG_FRAME_HEIGHT: cfg_height = val[FrameHeightW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_frame(input int unsigned len, input bit fs_first, input bit noisy);
    pix_beat_t b;
    for (int unsigned j = 0; j < len; j++) begin
      b.pixel = pix_t'($urandom_range(0, 255));
      b.frame_start = (j == 0) ? fs_first : (noisy && $urandom_range(0, 49) == 0);
      pixel_q.push_back(b);
    end
  endtask

  // A pixel that produces no result may still be in flight when the last
  // expected beat arrives, so the task lets it drain before returning.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pixel_q.size() != 0 || s_axis_tvalid || filtered_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_wait <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_wait != 0) begin
        src_wait <= src_wait - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        s_axis_tdata <= pixel_q[0].pixel;
        s_axis_tuser <= pixel_q[0].frame_start;
        s_axis_tvalid <= 1'b1;
        src_wait <= src_idle_en ? $urandom_range(0, 15) : 0;
        void'(pixel_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      filter_pixel(s_axis_tdata, s_axis_tuser);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : sink_side
    int unsigned stall;
    filt_beat_t  want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, 8'h00);
      end else begin
        want = filtered_q.pop_front();
        if (m_axis_tdata !== want.pixel) begin
          report_mismatch("pixel_out", m_axis_tdata, want.pixel);
        end
        if (m_axis_tuser !== want.frame_end) begin
          report_mismatch("frame_end", {7'd0, m_axis_tuser}, {7'd0, want.frame_end});
        end
      end
      stall = snk_idle_en ? $urandom_range(0, 15) : 0;
      snk_wait <= stall;
      m_axis_tready <= (stall == 0) && !hold_sink;
    end else if (hold_sink) begin
      m_axis_tready <= 1'b0;
    end else if (snk_wait != 0) begin
      snk_wait <= snk_wait - 1;
      m_axis_tready <= (snk_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Long receiver hold-off while the source keeps streaming, so the block backs up.
  initial begin
    wait (stall_arm);
    repeat (50) @(posedge clk_i);
    hold_sink <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_sink <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stim
    int unsigned stim_cnt, ph, width, height, we, he, full, len, nframes, phase_items, pick;
    logic [63:0] taps;
    pix_t        last;
    stim_cnt = 0;
    ph = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: out-of-range sizes acting as 3x3, extreme pixels and taps,
    // a frame overrun and an early frame start.
    write_reg(CFG_TAPS_LOW, 64'h80FF_017F_FF00_0180);
    write_reg(CFG_TAP_LAST, 64'hFFFF_FFFF_FFFF_FF80);
    write_reg(CFG_LINE_WIDTH, 64'd0);
    write_reg(CFG_FRAME_HEIGHT, 64'd2);
    for (int j = 0; j < 9; j++) begin
      pixel_q.push_back('{pixel: (j % 2) ? 8'h00 : 8'hFF, frame_start: (j == 0)});
    end
    for (int j = 0; j < 9; j++) begin
      pixel_q.push_back('{pixel: (j == 4) ? 8'h00 : 8'hFF, frame_start: 1'b0});
    end
    push_frame(4, 1'b0, 1'b0);
    push_frame(9, 1'b1, 1'b0);

    while (ph < 2 || stim_cnt < 2000) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      case (pick)
        0:       width = $urandom_range(0, 2);
        1:       width = $urandom_range(13, 40);
        2:       width = 3;
        default: width = $urandom_range(4, 12);
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0:       height = $urandom_range(0, 2);
        1:       height = 65535;
        2:       height = $urandom_range(11, 65534);
        default: height = $urandom_range(3, 10);
      endcase
      pick = $urandom_range(0, 7);
      case (pick)
        0: begin
          taps = '1;
          last = 8'hFF;
        end
        1: begin
          taps = 64'h8080_8080_8080_8080;
          last = 8'h80;
        end
        2: begin
          taps = '0;
          last = 8'h00;
        end
        default: begin
          taps = {$urandom, $urandom};
          last = pix_t'($urandom_range(0, 255));
        end
      endcase
      write_reg(CFG_TAPS_LOW, taps);
      write_reg(CFG_TAP_LAST, {56'd0, last});
      write_reg(CFG_LINE_WIDTH, 64'(width));
      write_reg(CFG_FRAME_HEIGHT, 64'(height));
      we = (width < 3) ? 3 : width;
      he = (height < 3) ? 3 : height;
      full = (he <= 12) ? we * he : we * $urandom_range(3, 6);
      src_idle_en = (ph != 1) && ($urandom_range(0, 2) != 0);
      snk_idle_en = ($urandom_range(0, 2) != 0);
      nframes = $urandom_range(1, 4);
      phase_items = 0;
      // Mostly whole frames; some are cut short, continue without a frame
      // start, or carry stray frame starts.
      for (int unsigned f = 0;
           (f < nframes && stim_cnt + phase_items < 2000) ||
           phase_items < ((ph == 1) ? 300 : 0);
           f++) begin
        pick = $urandom_range(0, 9);
        len = (pick == 0 && full > 1) ? $urandom_range(1, full - 1) : full;
        push_frame(len, (f == 0) || (pick != 1), pick == 2);
        phase_items += len;
      end
      stim_cnt += phase_items;
      if (ph == 1) begin
        stall_arm = 1'b1;
      end
      ph++;
    end

    wait_idle();

    if (filtered_q.size() != 0) begin
      report_mismatch("missing beats", 8'h00, 8'(filtered_q.size()));
    end
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
